// File: sv/first_owner_hash_pair_marker_defines.svh
// Assertion helpers used by the marker module.
`ifndef FIRST_OWNER_HASH_PAIR_MARKER_DEFINES_SVH
`define FIRST_OWNER_HASH_PAIR_MARKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FOHPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FOHPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/fohpm_pkg.sv
package fohpm_pkg;

    localparam int TABLE_SIZE  = 64;   // power of two: the hash keeps the low bits
    localparam int IDX_W       = $clog2(TABLE_SIZE);
    localparam int MAX_PERSONS = 32;
    localparam int PAIR_IDX_W  = $clog2(MAX_PERSONS + 1);
    localparam int PAIR_ROW_W  = MAX_PERSONS + 1;
    localparam int KEY_W       = 32;
    localparam int ID_W        = 6;
    localparam int COUNT_W     = 11;

    localparam logic [KEY_W-1:0]   HASH_ADD  = KEY_W'(3);
    localparam logic [KEY_W-1:0]   HASH_MUL  = KEY_W'(11);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_PAIR,
        ST_DONE
    } fohpm_state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  owner;
    } slot_entry_t;

    typedef struct packed {
        logic                  valid;
        logic [PAIR_IDX_W-1:0] row;
        logic [PAIR_IDX_W-1:0] col;
    } pair_req_t;

    typedef struct packed {
        logic valid;
        logic newly_set;
    } pair_rsp_t;

endpackage

// File: sv/first_owner_hash_pair_marker.sv
// Steps: an accepted word goes to a probe; a new key landing in an empty slot is stored
// there and goes to the result step; each occupied slot adds a probe (one slot memory read)
// and a compare, and a found key with both ids in range adds the pair-row read-modify-write.
// Flow: one word at a time; a new word is accepted only after the last result is
// registered for output, and a result-side stall holds the block in its result step.
// Reset clears the slot used bits, pair-row valid bits and the pair count at once; no
// clearing pass is needed, the block accepts words right after reset.
`include "first_owner_hash_pair_marker_defines.svh"

module first_owner_hash_pair_marker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item_key[31:0], person_id[37:32], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // owner_id[5:0], slot_index[11:6], pair_count[22:12], pad
    output logic [1:0]  m_tuser    // already_present[0], table_full[1]
);
    import fohpm_pkg::*;

    fohpm_state_t state_reg, state_next;

    slot_entry_t slot_mem [TABLE_SIZE];
    slot_entry_t slot_rdata;
    logic        slot_we;
    logic        slot_re;

    logic [TABLE_SIZE-1:0] used_reg, used_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [ID_W-1:0]       person_reg, person_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      probe_reg, probe_next;
    logic                  present_reg, present_next;
    logic [ID_W-1:0]       owner_reg, owner_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic                  full_reg, full_next;
    logic [COUNT_W-1:0]    total_reg, total_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [23:0]           m_tdata_reg, m_tdata_next;
    logic [1:0]            m_tuser_reg, m_tuser_next;

    logic [KEY_W-1:0] in_key;
    logic [ID_W-1:0]  in_person;
    logic [KEY_W-1:0] hash_prod;
    logic             key_hit;
    logic             ids_in_range;
    logic             last_probe;
    logic             out_free;
    pair_req_t        pair_req;
    pair_rsp_t        pair_rsp;

    assign in_key    = s_tdata[KEY_W-1:0];
    assign in_person = s_tdata[KEY_W+ID_W-1:KEY_W];
    assign hash_prod = (in_key + HASH_ADD) * HASH_MUL;

    assign key_hit      = slot_rdata.key == key_reg;
    assign ids_in_range = (32'(slot_rdata.owner) <= MAX_PERSONS) &&
                          (32'(person_reg) <= MAX_PERSONS);
    assign last_probe   = probe_reg == IDX_W'(TABLE_SIZE - 1);
    assign out_free     = !m_tvalid_reg || m_tready;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    fohpm_pair_store u_pair_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pair_req),
        .rsp   (pair_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                state_next = used_reg[idx_reg] ? ST_COMPARE : ST_DONE;
            end
            ST_COMPARE:
            begin
                if (key_hit)
                begin
                    state_next = ids_in_range ? ST_PAIR : ST_DONE;
                end
                else
                begin
                    state_next = last_probe ? ST_DONE : ST_PROBE;
                end
            end
            ST_PAIR:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        used_next     = used_reg;
        key_next      = key_reg;
        person_next   = person_reg;
        idx_next      = idx_reg;
        probe_next    = probe_reg;
        present_next  = present_reg;
        owner_next    = owner_reg;
        slot_next     = slot_reg;
        full_next     = full_reg;
        total_next    = total_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        slot_we       = 1'b0;
        slot_re       = 1'b0;
        pair_req      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                key_next    = in_key;
                person_next = in_person;
                idx_next    = hash_prod[IDX_W-1:0];
                probe_next  = '0;
            end
            ST_PROBE:
            begin
                if (used_reg[idx_reg])
                begin
                    slot_re = 1'b1;
                end
                else
                begin
                    // Claim the empty slot for the new key.
                    slot_we            = 1'b1;
                    used_next[idx_reg] = 1'b1;
                    present_next       = 1'b0;
                    owner_next         = person_reg;
                    slot_next          = idx_reg;
                    full_next          = 1'b0;
                end
            end
            ST_COMPARE:
            begin
                if (key_hit)
                begin
                    present_next  = 1'b1;
                    owner_next    = slot_rdata.owner;
                    slot_next     = idx_reg;
                    full_next     = 1'b0;
                    pair_req.valid = ids_in_range;
                    pair_req.row   = PAIR_IDX_W'(slot_rdata.owner);
                    pair_req.col   = PAIR_IDX_W'(person_reg);
                end
                else if (last_probe)
                begin
                    // Drop the key: no empty slot left.
                    present_next = 1'b0;
                    owner_next   = '0;
                    slot_next    = '0;
                    full_next    = 1'b1;
                end
                else
                begin
                    idx_next   = (idx_reg == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                end
            end
            ST_PAIR:
            begin
                if (pair_rsp.newly_set && (total_reg != COUNT_MAX))
                begin
                    total_next = total_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, total_reg, 6'(slot_reg), owner_reg};
                    m_tuser_next  = {full_reg, present_reg};
                end
            end
            default:
            begin
                slot_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[idx_reg] <= '{key: key_reg, owner: person_reg};
        end
        if (slot_re)
        begin
            slot_rdata <= slot_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        person_reg  <= person_next;
        idx_reg     <= idx_next;
        probe_reg   <= probe_next;
        present_reg <= present_next;
        owner_reg   <= owner_next;
        slot_reg    <= slot_next;
        full_reg    <= full_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `FOHPM_ASSERT_NEXT(a_accept_starts_probe, s_tvalid && s_tready,
        state_reg == ST_PROBE, "accepted word did not start a probe")
    `FOHPM_ASSERT_NOW(a_pair_rsp_in_pair, state_reg == ST_PAIR,
        pair_rsp.valid, "pair row not read back in pair step")
    `FOHPM_ASSERT_NEXT(a_total_monotonic, 1'b1,
        total_reg >= $past(total_reg), "pair count went down")
    `FOHPM_ASSERT_NOW(a_flags_exclusive, m_tvalid,
        !(m_tuser[0] && m_tuser[1]), "found and full flagged together")

endmodule

// File: sv/fohpm_pair_store.sv
module fohpm_pair_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fohpm_pkg::pair_req_t req,
    output fohpm_pkg::pair_rsp_t rsp
);
    import fohpm_pkg::*;

    logic [PAIR_ROW_W-1:0] row_mem [PAIR_ROW_W];
    logic [PAIR_ROW_W-1:0] rdata_reg;
    logic [PAIR_ROW_W-1:0] row_valid_reg;
    logic [PAIR_ROW_W-1:0] row_valid_next;
    logic                  pend_reg;
    logic [PAIR_IDX_W-1:0] row_q_reg;
    logic [PAIR_IDX_W-1:0] col_q_reg;
    logic [PAIR_ROW_W-1:0] row_cur;
    logic [PAIR_ROW_W-1:0] row_merged;
    logic                  bit_set;

    // Rows never written read as all zero.
    always_comb
    begin
        row_cur        = row_valid_reg[row_q_reg] ? rdata_reg : '0;
        bit_set        = row_cur[col_q_reg];
        row_merged     = row_cur | (PAIR_ROW_W'(1) << col_q_reg);
        row_valid_next = row_valid_reg;
        if (pend_reg && !bit_set)
        begin
            row_valid_next[row_q_reg] = 1'b1;
        end
        rsp.valid     = pend_reg;
        rsp.newly_set = pend_reg && !bit_set;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            rdata_reg <= row_mem[req.row];
        end
        if (pend_reg && !bit_set)
        begin
            row_mem[row_q_reg] <= row_merged;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            row_q_reg <= req.row;
            col_q_reg <= req.col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            pend_reg      <= req.valid;
            row_valid_reg <= row_valid_next;
        end
    end

endmodule

// File: sim/hash_pair_checker.sv
`timescale 1ns / 1ps

module hash_pair_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // item_key[31:0], person_id[37:32], zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // owner_id[5:0], slot_index[11:6], pair_count[22:12], pad
    input  logic [1:0]  m_tuser,   // already_present[0], table_full[1]
    output int          fail_count,
    output int          pending
);
    import fohpm_pkg::*;

    typedef struct packed {
        logic               present;
        logic [ID_W-1:0]    owner;
        logic [IDX_W-1:0]   slot;
        logic [COUNT_W-1:0] count;
        logic               full;
    } mark_result_t;

    logic [KEY_W-1:0]   slot_key   [TABLE_SIZE];
    bit                 slot_used  [TABLE_SIZE];
    logic [ID_W-1:0]    slot_owner [TABLE_SIZE];
    bit                 pair_bits  [MAX_PERSONS+1][MAX_PERSONS+1];
    logic [COUNT_W-1:0] pair_total;

    mark_result_t expected_marks[$];

    // Walk the table from the home slot; store a new key or mark the (owner, person) pair, or flag a full table.
    function automatic mark_result_t insert_key(logic [KEY_W-1:0] key, logic [ID_W-1:0] person);
        mark_result_t     r;
        logic [KEY_W-1:0] h;
        logic [IDX_W-1:0] idx;
        bit               hit;
        bit               vacant;
        r      = '0;
        h      = (key + HASH_ADD) * HASH_MUL;
        idx    = h[IDX_W-1:0];
        hit    = 0;
        vacant = 0;
        for (int n = 0; n < TABLE_SIZE && !hit && !vacant; n++)
        begin
            if (!slot_used[idx])
                vacant = 1;
            else if (slot_key[idx] == key)
                hit = 1;
            else
                idx = idx + 1'b1;
        end
        if (hit)
        begin
            r.present = 1;
            r.owner   = slot_owner[idx];
            r.slot    = idx;
            // ids above the pair matrix are reported but never marked
            if (r.owner <= MAX_PERSONS && person <= MAX_PERSONS && !pair_bits[r.owner][person])
            begin
                pair_bits[r.owner][person] = 1;
                if (pair_total != COUNT_MAX)
                    pair_total = pair_total + 1'b1;
            end
        end
        else if (vacant)
        begin
            slot_key[idx]   = key;
            slot_owner[idx] = person;
            slot_used[idx]  = 1;
            r.owner         = person;
            r.slot          = idx;
        end
        else
            r.full = 1;
        r.count = pair_total;
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        mark_result_t want;
        mark_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
                slot_used[i] = 0;
            for (int i = 0; i <= MAX_PERSONS; i++)
                for (int j = 0; j <= MAX_PERSONS; j++)
                    pair_bits[i][j] = 0;
            pair_total = '0;
            expected_marks.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.present = m_tuser[0];
                got.full    = m_tuser[1];
                got.owner   = m_tdata[5:0];
                got.slot    = m_tdata[11:6];
                got.count   = m_tdata[22:12];
                if (expected_marks.size() == 0)
                begin
                    $error("unexpected result word: tdata %h tuser %b", m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_marks.pop_front();
                    if (got.present !== want.present)
                    begin
                        $error("already_present: expected %0d, got %0d", want.present, got.present);
                        fail_count++;
                    end
                    if (got.owner !== want.owner)
                    begin
                        $error("owner_id: expected %0d, got %0d", want.owner, got.owner);
                        fail_count++;
                    end
                    if (got.slot !== want.slot)
                    begin
                        $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
                        fail_count++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("pair_count: expected %0d, got %0d", want.count, got.count);
                        fail_count++;
                    end
                    if (got.full !== want.full)
                    begin
                        $error("table_full: expected %0d, got %0d", want.full, got.full);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_marks.push_back(insert_key(s_tdata[31:0], s_tdata[37:32]));
        end
        pending = expected_marks.size();
    end

endmodule

// File: sim/first_owner_hash_pair_marker_test.sv
`timescale 1ns / 1ps

module first_owner_hash_pair_marker_test;

    import fohpm_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;
    bit          steady;

    logic [KEY_W-1:0] known_keys[$];

    first_owner_hash_pair_marker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    hash_pair_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Stall the result side at random, except inside the steady window.
    initial
    begin
        m_tready = 0;
        forever
        begin
            @(negedge clk);
            m_tready = steady || ($urandom_range(99) >= 37);
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL first_owner_hash_pair_marker");
        $finish;
    end

    // Present one word, hold it until accepted, return at the next falling edge.
    task automatic send_key(input logic [KEY_W-1:0] key, input logic [ID_W-1:0] person);
        while (!steady && $urandom_range(99) < 37)
        begin
            s_tvalid = 0;
            @(negedge clk);
        end
        s_tvalid = 1;
        s_tdata  = {2'b00, person, key};
        known_keys.push_back(key);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [ID_W-1:0] pick_person();
        if ($urandom_range(99) < 85)
            return ID_W'($urandom_range(MAX_PERSONS, 1));
        return ID_W'($urandom_range(63, 0));
    endfunction

    initial
    begin
        int               fresh_pct;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] twin;
        s_tvalid = 0;
        s_tdata  = '0;
        rst_n    = 0;
        steady   = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_key(32'h0000_0000, 6'd1);
        send_key(32'h0000_0000, 6'd1);    // owner repeats: diagonal bit
        send_key(32'h0000_0000, 6'd2);
        send_key(32'h0000_0000, 6'd0);    // id zero uses column zero
        send_key(32'h0000_0000, 6'd63);   // out of range person: no mark
        send_key(32'h7FFF_FFFF, 6'd32);
        send_key(32'hFFFF_FFFF, 6'd0);    // same home slot, differs in bit 31 only
        send_key(32'hFFFF_FFFF, 6'd32);
        send_key(32'h8000_0000, 6'd33);   // out of range owner gets stored
        send_key(32'h8000_0000, 6'd5);
        send_key(32'h7FFF_FFFF, 6'd32);
        send_key(32'd26, 6'd3);           // home slot is the last one
        send_key(32'd90, 6'd4);           // probe wraps to slot zero
        send_key(32'd154, 6'd6);
        send_key(32'd154, 6'd7);
        send_key(32'd26, 6'd32);
        send_key(32'd90, 6'd3);

        for (int i = 0; i < 450; i++)
        begin
            steady    = (i >= 150 && i < 260);
            fresh_pct = (known_keys.size() < TABLE_SIZE + 24) ? 45 : 10;
            twin      = known_keys[$urandom_range(known_keys.size() - 1, 0)];
            if ($urandom_range(99) < fresh_pct)
            begin
                key = $urandom;
                // share a home slot with a known key to force probing
                if ($urandom_range(2, 0) == 0)
                    key[IDX_W-1:0] = twin[IDX_W-1:0];
            end
            else
                key = twin;
            send_key(key, pick_person());
        end
        s_tvalid = 0;
        steady   = 0;

        wait (pending == 0);
        repeat (150) @(posedge clk);
        if (fail_count == 0)
            $display("PASS first_owner_hash_pair_marker");
        else
            $display("FAIL first_owner_hash_pair_marker");
        $finish;
    end

endmodule
